// ----- hdl/ngga_pkg.sv -----
// Shared types and fixed field widths for the GGA position parser.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package ngga_pkg;

	localparam int LAT_W    = 30;
	localparam int LON_W    = 31;
	localparam int SAT_W    = 7;
	localparam int LATDEG_W = 31;
	localparam int LONDEG_W = 32;

	// Hemisphere letter code: none seen, first letter (N or E),
	// second letter (S or W), or anything else.
	typedef enum logic [1:0] {
		HEM_NONE,
		HEM_FIRST,
		HEM_SECOND,
		HEM_OTHER
	} hem_t;

	// One finished sentence as handed from the parser to the converter.
	typedef struct packed {
		logic [LAT_W-1:0] lat_raw;
		logic [LON_W-1:0] lon_raw;
		hem_t             ns;
		hem_t             ew;
		logic [SAT_W-1:0] sats;
		logic             overflow;
	} rec_t;

endpackage

// ----- hdl/ngga_front.sv -----
// Byte-level sentence parser: header match, field counting and number capture.
// Depends on ngga_pkg; emits one rec_t per carriage return inside a capture.
`timescale 1ns / 1ps

module ngga_front #(
	parameter int FRACTION_DIGITS = 5
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          byte_take,
	input  logic [7:0]    rx_byte,
	output logic          rec_push,
	output ngga_pkg::rec_t rec_data
);
	import ngga_pkg::*;

	localparam logic [7:0]  CH_DOLLAR = 8'h24;
	localparam logic [7:0]  CH_COMMA  = 8'h2C;
	localparam logic [7:0]  CH_DOT    = 8'h2E;
	localparam logic [7:0]  CH_CR     = 8'h0D;
	localparam logic [7:0]  CH_ZERO   = 8'h30;
	localparam logic [7:0]  CH_NINE   = 8'h39;
	localparam logic [7:0]  CH_N      = 8'h4E;
	localparam logic [7:0]  CH_S      = 8'h53;
	localparam logic [7:0]  CH_E      = 8'h45;
	localparam logic [7:0]  CH_W      = 8'h57;
	localparam logic [23:0] MATCH_GGA = 24'h474741;

	localparam logic [3:0] FLD_LAT  = 4'd1;
	localparam logic [3:0] FLD_NS   = 4'd2;
	localparam logic [3:0] FLD_LON  = 4'd3;
	localparam logic [3:0] FLD_EW   = 4'd4;
	localparam logic [3:0] FLD_SATS = 4'd6;
	localparam logic [3:0] FLD_LAST = 4'd15;

	localparam logic [SAT_W-1:0] SAT_MAX = 7'd99;

	localparam longint unsigned SCALE    = 64'(10 ** FRACTION_DIGITS);
	localparam longint unsigned LAT_FULL = 64'd9000 * SCALE;
	localparam longint unsigned LON_FULL = 64'd18000 * SCALE;
	localparam logic [LAT_W-1:0] LAT_LIM =
		(LAT_FULL < 64'h3FFF_FFFF) ? LAT_W'(LAT_FULL) : {LAT_W{1'b1}};
	localparam logic [LON_W-1:0] LON_LIM =
		(LON_FULL < 64'h7FFF_FFFF) ? LON_W'(LON_FULL) : {LON_W{1'b1}};

	// Wide enough for ten times the largest accumulator plus one scaled digit.
	localparam int CO_W = LON_W + 5;

	function automatic logic [19:0] pow10_f(input logic [2:0] k);
		logic [19:0] r;
		case (k)
			3'd0:    r = 20'd1;
			3'd1:    r = 20'd10;
			3'd2:    r = 20'd100;
			3'd3:    r = 20'd1000;
			3'd4:    r = 20'd10000;
			3'd5:    r = 20'd100000;
			default: r = 20'd1000000;
		endcase
		return r;
	endfunction

	function automatic hem_t hem_next(input hem_t cur, input logic [7:0] c,
			input logic [7:0] first, input logic [7:0] second);
		hem_t r;
		if (cur != HEM_NONE) begin
			r = HEM_OTHER;
		end else if (c == first) begin
			r = HEM_FIRST;
		end else if (c == second) begin
			r = HEM_SECOND;
		end else begin
			r = HEM_OTHER;
		end
		return r;
	endfunction

	logic             capturing_q;
	logic [23:0]      recent_q;
	logic [3:0]       field_q;
	logic [LAT_W-1:0] lat_acc_q;
	logic [LON_W-1:0] lon_acc_q;
	logic [2:0]       frac_cnt_q;
	logic             point_q;
	logic             done_q;
	hem_t             ns_q;
	hem_t             ew_q;
	logic [SAT_W-1:0] sat_q;
	logic             ovf_q;

	logic             is_digit;
	logic [3:0]       digit;
	logic             on_lat;
	logic             frac_room;
	logic [2:0]       pow_idx;
	logic [LON_W-1:0] acc_sel;
	logic [LON_W-1:0] lim_sel;
	logic [CO_W-1:0]  v_int;
	logic [CO_W-1:0]  v_frac;
	logic [CO_W-1:0]  v_pick;
	logic             coord_ovf;
	logic [LON_W-1:0] coord_val;
	logic [9:0]       sat_v;

	assign is_digit  = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
	assign digit     = 4'(rx_byte - CH_ZERO);
	assign on_lat    = (field_q == FLD_LAT);
	assign frac_room = (frac_cnt_q < 3'(FRACTION_DIGITS));
	assign pow_idx   = 3'(FRACTION_DIGITS - 1) - frac_cnt_q;

	// Latitude and longitude never update in the same byte, so one
	// accumulate-and-saturate path serves both.
	assign acc_sel = on_lat ? LON_W'(lat_acc_q) : lon_acc_q;
	assign lim_sel = on_lat ? LON_W'(LAT_LIM) : LON_LIM;
	assign v_int   = CO_W'(acc_sel) * CO_W'(10) + CO_W'(digit) * CO_W'(SCALE);
	assign v_frac  = CO_W'(acc_sel) + CO_W'(digit) * CO_W'(pow10_f(pow_idx));
	assign v_pick  = point_q ? v_frac : v_int;
	assign coord_ovf = (v_pick > CO_W'(lim_sel));
	assign coord_val = coord_ovf ? lim_sel : LON_W'(v_pick);

	assign sat_v = 10'(sat_q) * 10'd10 + 10'(digit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capturing_q <= 1'b0;
			recent_q    <= '0;
			field_q     <= '0;
			lat_acc_q   <= '0;
			lon_acc_q   <= '0;
			frac_cnt_q  <= '0;
			point_q     <= 1'b0;
			done_q      <= 1'b0;
			ns_q        <= HEM_NONE;
			ew_q        <= HEM_NONE;
			sat_q       <= '0;
			ovf_q       <= 1'b0;
		end else if (byte_take) begin
			if (rx_byte == CH_DOLLAR) begin
				capturing_q <= 1'b0;
			end else if (capturing_q) begin
				if (rx_byte == CH_CR) begin
					capturing_q <= 1'b0;
				end else if (rx_byte == CH_COMMA) begin
					if (field_q != FLD_LAST) begin
						field_q <= field_q + 4'd1;
					end
					frac_cnt_q <= '0;
					point_q    <= 1'b0;
					done_q     <= 1'b0;
				end else begin
					case (field_q)
						FLD_LAT, FLD_LON: begin
							if (!done_q) begin
								if (is_digit) begin
									if (!point_q || frac_room) begin
										if (point_q) begin
											frac_cnt_q <= frac_cnt_q + 3'd1;
										end
										if (on_lat) begin
											lat_acc_q <= LAT_W'(coord_val);
										end else begin
											lon_acc_q <= coord_val;
										end
										if (coord_ovf) begin
											ovf_q <= 1'b1;
										end
									end
								end else if (rx_byte == CH_DOT && !point_q) begin
									point_q <= 1'b1;
								end else begin
									done_q <= 1'b1;
								end
							end
						end
						FLD_NS: begin
							ns_q <= hem_next(ns_q, rx_byte, CH_N, CH_S);
						end
						FLD_EW: begin
							ew_q <= hem_next(ew_q, rx_byte, CH_E, CH_W);
						end
						FLD_SATS: begin
							if (!done_q) begin
								if (is_digit) begin
									if (sat_v > 10'(SAT_MAX)) begin
										sat_q <= SAT_MAX;
										ovf_q <= 1'b1;
									end else begin
										sat_q <= SAT_W'(sat_v);
									end
								end else begin
									done_q <= 1'b1;
								end
							end
						end
						default: begin
						end
					endcase
				end
			end else if (recent_q == MATCH_GGA) begin
				// The byte after the header opens the capture and is not parsed.
				capturing_q <= 1'b1;
				recent_q    <= '0;
				field_q     <= '0;
				lat_acc_q   <= '0;
				lon_acc_q   <= '0;
				frac_cnt_q  <= '0;
				point_q     <= 1'b0;
				done_q      <= 1'b0;
				ns_q        <= HEM_NONE;
				ew_q        <= HEM_NONE;
				sat_q       <= '0;
				ovf_q       <= 1'b0;
			end else begin
				recent_q <= {recent_q[15:0], rx_byte};
			end
		end
	end

	assign rec_push = byte_take && capturing_q && (rx_byte == CH_CR);

	assign rec_data.lat_raw  = lat_acc_q;
	assign rec_data.lon_raw  = lon_acc_q;
	assign rec_data.ns       = ns_q;
	assign rec_data.ew       = ew_q;
	assign rec_data.sats     = sat_q;
	assign rec_data.overflow = ovf_q;

endmodule

// ----- hdl/ngga_queue.sv -----
// Small first-in first-out queue of parsed sentences between parser and converter.
// Depends on ngga_pkg for the record type.
`timescale 1ns / 1ps

module ngga_queue #(
	parameter int DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  ngga_pkg::rec_t wr_data,
	output logic           full,
	input  logic           rd_en,
	output logic           rd_valid,
	output ngga_pkg::rec_t rd_data
);
	import ngga_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	rec_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign full     = (count_q == CNT_W'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (rd_en) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + CNT_W'(1);
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	a_no_write_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && full))
		else $error("sentence written into a full queue");

	a_no_read_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> rd_valid)
		else $error("sentence popped from an empty queue");

endmodule

// ----- hdl/ngga_back.sv -----
// Degree converter: splits raw minutes into degrees and minutes by reciprocal
// multiplication with one correction step, scales to 1e7 and drives the result register.
// Uses ngga_pkg.
`timescale 1ns / 1ps

module ngga_back #(
	parameter int FRACTION_DIGITS = 5
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           rd_valid,
	input  ngga_pkg::rec_t                 rd_data,
	output logic                           rd_en,
	input  logic                           out_stall,
	output logic                           out_valid,
	output logic [ngga_pkg::LAT_W-1:0]     lat_minutes_raw,
	output logic                           lat_south,
	output logic [ngga_pkg::LON_W-1:0]     lon_minutes_raw,
	output logic                           lon_west,
	output logic [ngga_pkg::SAT_W-1:0]     satellites,
	output logic signed [ngga_pkg::LATDEG_W-1:0] lat_degrees,
	output logic signed [ngga_pkg::LONDEG_W-1:0] lon_degrees,
	output logic                           conversion_valid,
	output logic                           value_saturated
);
	import ngga_pkg::*;

	localparam longint unsigned DEG_SCALE   = 64'd10000000;
	localparam longint unsigned MIN_PER_DEG = 64'd60;
	localparam int SUM_W   = 31;
	localparam int WHOLE_W = 8;
	localparam int Y_W     = 30;
	localparam int Q2_W    = 24;
	localparam int R2_W    = 7;

	localparam longint unsigned SCALE  = 64'(10 ** FRACTION_DIGITS);
	localparam longint unsigned UNIT   = 64'd100 * SCALE;
	// Minutes times MIN_K, divided by 60, equals minutes * 1e7 / (60 * scale).
	localparam longint unsigned MIN_K  = DEG_SCALE / SCALE;
	// Floor reciprocals at 2^32; each estimate is the true quotient or one below it.
	localparam longint unsigned RECIP1 = (64'd1 << 32) / UNIT;
	localparam longint unsigned RECIP2 = (64'd1 << 32) / MIN_PER_DEG;

	localparam logic [LON_W-1:0] UNIT_W      = LON_W'(UNIT);
	localparam logic [R2_W-1:0]  SIXTY_W     = R2_W'(MIN_PER_DEG);
	localparam logic [SUM_W-1:0] LAT_DEG_MAX = SUM_W'(64'd90 * DEG_SCALE);
	localparam logic [SUM_W-1:0] LON_DEG_MAX = SUM_W'(64'd180 * DEG_SCALE);

	typedef enum logic [3:0] {
		S_IDLE,
		S_EST1,
		S_REM1,
		S_FIX1,
		S_MUL,
		S_EST2,
		S_REM2,
		S_ADD,
		S_FIN,
		S_DONE
	} state_t;

	state_t                state_q;
	rec_t                  rec_q;
	logic                  lon_phase_q;
	logic [WHOLE_W-1:0]    whole_q;
	logic [LON_W-1:0]      rem_q;
	logic [Y_W-1:0]        y_q;
	logic [Q2_W-1:0]       q2_q;
	logic [R2_W-1:0]       r2_q;
	logic [SUM_W-1:0]      whole_sc_q;
	logic [SUM_W-1:0]      sum_q;
	logic [LATDEG_W-1:0]   lat_deg_q;
	logic [LONDEG_W-1:0]   lon_deg_q;
	logic                  clamp_q;

	logic [LON_W-1:0]      raw_sel;
	logic [63:0]           prod1;
	logic [63:0]           prod2;
	logic [Y_W-1:0]        r2_full;
	logic                  neg;
	logic                  rec_ok;
	logic                  out_free;
	logic [SUM_W-1:0]      lim;
	logic                  over;
	logic [SUM_W-1:0]      v_cl;

	assign raw_sel  = lon_phase_q ? rec_q.lon_raw : LON_W'(rec_q.lat_raw);
	assign prod1    = 64'(raw_sel) * 64'(RECIP1);
	assign prod2    = 64'(y_q) * 64'(RECIP2);
	assign r2_full  = y_q - Y_W'(64'(q2_q) * MIN_PER_DEG);
	assign neg      = lon_phase_q ? (rec_q.ew == HEM_SECOND) : (rec_q.ns == HEM_SECOND);
	assign rec_ok   = ((rec_q.ns == HEM_FIRST) || (rec_q.ns == HEM_SECOND)) &&
	                  ((rec_q.ew == HEM_FIRST) || (rec_q.ew == HEM_SECOND));
	assign out_free = !out_valid || !out_stall;
	assign lim      = lon_phase_q ? LON_DEG_MAX : LAT_DEG_MAX;
	assign over     = (sum_q > lim);
	assign v_cl     = over ? lim : sum_q;
	assign rd_en    = (state_q == S_IDLE) && rd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= S_IDLE;
			rec_q            <= '0;
			lon_phase_q      <= 1'b0;
			whole_q          <= '0;
			rem_q            <= '0;
			y_q              <= '0;
			q2_q             <= '0;
			r2_q             <= '0;
			whole_sc_q       <= '0;
			sum_q            <= '0;
			lat_deg_q        <= '0;
			lon_deg_q        <= '0;
			clamp_q          <= 1'b0;
			out_valid        <= 1'b0;
			lat_minutes_raw  <= '0;
			lat_south        <= 1'b0;
			lon_minutes_raw  <= '0;
			lon_west         <= 1'b0;
			satellites       <= '0;
			lat_degrees      <= '0;
			lon_degrees      <= '0;
			conversion_valid <= 1'b0;
			value_saturated  <= 1'b0;
		end else begin
			if (out_valid && !out_stall && state_q != S_DONE) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (rd_valid) begin
						rec_q       <= rd_data;
						lon_phase_q <= 1'b0;
						clamp_q     <= 1'b0;
						state_q     <= S_EST1;
					end
				end
				S_EST1: begin
					whole_q <= prod1[32 +: WHOLE_W];
					state_q <= S_REM1;
				end
				S_REM1: begin
					rem_q   <= raw_sel - LON_W'(64'(whole_q) * UNIT);
					state_q <= S_FIX1;
				end
				S_FIX1: begin
					// The estimate may be one short; one compare and subtract settles it.
					if (rem_q >= UNIT_W) begin
						whole_q <= whole_q + WHOLE_W'(1);
						rem_q   <= rem_q - UNIT_W;
					end
					state_q <= S_MUL;
				end
				S_MUL: begin
					// Remainder is the minutes part; scale it for the divide by 60.
					whole_sc_q <= SUM_W'(32'(whole_q) * 32'(DEG_SCALE));
					y_q        <= Y_W'(64'(rem_q) * MIN_K);
					state_q    <= S_EST2;
				end
				S_EST2: begin
					q2_q    <= prod2[32 +: Q2_W];
					state_q <= S_REM2;
				end
				S_REM2: begin
					r2_q    <= r2_full[R2_W-1:0];
					state_q <= S_ADD;
				end
				S_ADD: begin
					sum_q   <= whole_sc_q + SUM_W'(q2_q) + SUM_W'(r2_q >= SIXTY_W);
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (over) begin
						clamp_q <= 1'b1;
					end
					if (lon_phase_q) begin
						lon_deg_q <= neg ? LONDEG_W'(0) - LONDEG_W'(v_cl) : LONDEG_W'(v_cl);
						state_q   <= S_DONE;
					end else begin
						lat_deg_q   <= neg ? LATDEG_W'(0) - LATDEG_W'(v_cl) : LATDEG_W'(v_cl);
						lon_phase_q <= 1'b1;
						state_q     <= S_EST1;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid        <= 1'b1;
						lat_minutes_raw  <= rec_q.lat_raw;
						lat_south        <= (rec_q.ns == HEM_SECOND);
						lon_minutes_raw  <= rec_q.lon_raw;
						lon_west         <= (rec_q.ew == HEM_SECOND);
						satellites       <= rec_q.sats;
						lat_degrees      <= rec_ok ? lat_deg_q : '0;
						lon_degrees      <= rec_ok ? lon_deg_q : '0;
						conversion_valid <= rec_ok;
						value_saturated  <= rec_q.overflow || (rec_ok && clamp_q);
						state_q          <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == S_DONE))
		else $error("result raised outside the hand-off state");

	a_invalid_gives_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !conversion_valid) |-> (lat_degrees == '0 && lon_degrees == '0))
		else $error("degrees reported for an unknown hemisphere");

	a_east_not_negative: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && conversion_valid && !lon_west) |-> !lon_degrees[LONDEG_W-1])
		else $error("eastern longitude came out negative");

endmodule

// ----- hdl/nmea_gga_position_parser_core.sv -----
// Top level of the GGA position parser: byte parser, sentence queue, degree converter.
// Depends on ngga_pkg, ngga_front, ngga_queue and ngga_back.
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Payload
// input     in         in_valid / in_stall   rx_byte
// output    out        out_valid / out_stall lat_minutes_raw, lat_south, lon_minutes_raw,
//                                            lon_west, satellites, lat_degrees,
//                                            lon_degrees, conversion_valid, value_saturated
//
// A byte is taken in every cycle that one is offered unless the queue is full; the
// parser updates its field state in that same cycle. A carriage return inside a capture
// places one finished sentence in a queue of QUEUE_DEPTH entries. The converter pops a
// sentence, then runs for each coordinate a reciprocal-multiply estimate, a remainder, a
// one-step correction, a scale, a second estimate and remainder, an add and a clamp, then
// hands the result off, then pops the next. in_stall rises only while the queue is full;
// out_stall holds the result register while the converter finishes the next sentence.
// Reset is asynchronous and active low and clears all parse state and the queue.

module nmea_gga_position_parser_core #(
	parameter int FRACTION_DIGITS = 5,
	parameter int QUEUE_DEPTH     = 4
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [7:0]                           rx_byte,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [ngga_pkg::LAT_W-1:0]           lat_minutes_raw,
	output logic                                 lat_south,
	output logic [ngga_pkg::LON_W-1:0]           lon_minutes_raw,
	output logic                                 lon_west,
	output logic [ngga_pkg::SAT_W-1:0]           satellites,
	output logic signed [ngga_pkg::LATDEG_W-1:0] lat_degrees,
	output logic signed [ngga_pkg::LONDEG_W-1:0] lon_degrees,
	output logic                                 conversion_valid,
	output logic                                 value_saturated
);
	import ngga_pkg::*;

	// A byte transfer happens when the source offers a byte and the queue has room.
	// Stalling on a full queue for every byte keeps a closing carriage return
	// from ever finding no place for its sentence.
	logic byte_take;
	logic rec_push;
	rec_t rec_wr;
	logic q_full;
	logic q_rd_en;
	logic q_rd_valid;
	rec_t rec_rd;

	assign in_stall  = q_full;
	assign byte_take = in_valid && !q_full;

	// Front: header match, comma counting and saturating number capture.
	ngga_front #(
		.FRACTION_DIGITS(FRACTION_DIGITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_take(byte_take),
		.rx_byte  (rx_byte),
		.rec_push (rec_push),
		.rec_data (rec_wr)
	);

	// The queue decouples byte parsing from the much slower degree conversion.
	ngga_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (rec_push),
		.wr_data (rec_wr),
		.full    (q_full),
		.rd_en   (q_rd_en),
		.rd_valid(q_rd_valid),
		.rd_data (rec_rd)
	);

	// Back: degrees and minutes split, scaling to 1e7, sign and clamp, result register.
	ngga_back #(
		.FRACTION_DIGITS(FRACTION_DIGITS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.rd_valid        (q_rd_valid),
		.rd_data         (rec_rd),
		.rd_en           (q_rd_en),
		.out_stall       (out_stall),
		.out_valid       (out_valid),
		.lat_minutes_raw (lat_minutes_raw),
		.lat_south       (lat_south),
		.lon_minutes_raw (lon_minutes_raw),
		.lon_west        (lon_west),
		.satellites      (satellites),
		.lat_degrees     (lat_degrees),
		.lon_degrees     (lon_degrees),
		.conversion_valid(conversion_valid),
		.value_saturated (value_saturated)
	);

endmodule
